// ----- hw/rtl/demeg_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the dual encoder menu event generator.
// No dependencies; imported by the front, queue, back and top-level modules.
package demeg_pkg;

    localparam int CFG_W     = 16;
    localparam int TIME_W    = 32;
    localparam int POS_W     = 8;
    localparam int KIND_W    = 3;
    localparam int TICK_W    = 4;
    localparam int CFG_IDX_W = 2;
    localparam int S_DATA_W  = 40;
    localparam int M_DATA_W  = 48;
    localparam int NUM_EV    = 4;

    // Event kinds as they appear on the result stream.
    localparam logic [KIND_W-1:0] KIND_MAIN_ROTATE  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_SUB_ROTATE   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_TALK_PRESS   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_TALK_RELEASE = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CONFIRM      = 3'd4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_DEBOUNCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROTATE_LIMIT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_GUARD = 2'd2;

    // Bit positions in the per-tick event mask, in emission order.
    localparam int EV_MAIN    = 0;
    localparam int EV_SUB     = 1;
    localparam int EV_TALK    = 2;
    localparam int EV_CONFIRM = 3;

    // Everything the back end needs to emit all events of one tick.
    typedef struct packed {
        logic [NUM_EV-1:0] ev_mask;
        logic              talk_release;
        logic [POS_W-1:0]  main_pos;
        logic [POS_W-1:0]  sub_pos;
        logic [TIME_W-1:0] now_ms;
    } tick_rec_t;

endpackage

// ----- hw/rtl/demeg_front.sv -----
`timescale 1ns / 1ps
// Front end: holds the configuration and all tracking state, classifies one tick
// per word and produces a tick record when the tick yields events. Uses demeg_pkg.
module demeg_front #(
    parameter int WARMUP_TICKS = 10
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [demeg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [demeg_pkg::CFG_W-1:0]      cfg_wdata,
    input  logic                             tick_accept,
    input  logic [demeg_pkg::TIME_W-1:0]     now_ms,
    input  logic                             main_clock_level,
    input  logic                             main_data_level,
    input  logic                             sub_clock_level,
    input  logic                             sub_data_level,
    input  logic                             talk_button_level,
    input  logic                             confirm_switch_level,
    output logic                             rec_push,
    output demeg_pkg::tick_rec_t             rec_data
);
    import demeg_pkg::*;

    logic [CFG_W-1:0]  step_deb_reg, rate_lim_reg, guard_reg;
    logic              main_prev_reg, sub_prev_reg;
    logic [TIME_W-1:0] main_step_reg, sub_step_reg, main_evt_reg, sub_evt_reg;
    logic [POS_W-1:0]  main_pos_reg, sub_pos_reg;
    logic              talk_held_reg, talk_valid_reg, confirm_held_reg;
    logic [TIME_W-1:0] talk_rel_reg, confirm_rel_reg;
    logic [TICK_W-1:0] tick_reg;

    logic [TICK_W-1:0] tick_next;
    logic              warm;
    logic              main_edge, sub_edge, main_go, sub_go;
    logic [POS_W-1:0]  main_pos_next, sub_base, sub_pos_next;
    logic              talk_down, confirm_down;
    logic              talk_press, talk_rel, confirm_press, confirm_rel;
    logic              talk_guard_ok, confirm_guard_ok;

    assign tick_next = (tick_reg < TICK_W'(WARMUP_TICKS)) ? tick_reg + 1'b1 : tick_reg;
    assign warm      = tick_next < TICK_W'(WARMUP_TICKS);

    // A falling clock edge counts only once the step debounce window has closed.
    assign main_edge = ((now_ms - main_step_reg) >= {16'd0, step_deb_reg})
                       && main_prev_reg && !main_clock_level;
    assign sub_edge  = ((now_ms - sub_step_reg) >= {16'd0, step_deb_reg})
                       && sub_prev_reg && !sub_clock_level;

    assign main_go = !warm && main_edge && ((now_ms - main_evt_reg) >= {16'd0, rate_lim_reg});
    assign sub_go  = !warm && sub_edge && ((now_ms - sub_evt_reg) >= {16'd0, rate_lim_reg});

    assign main_pos_next = main_go ? main_pos_reg + (main_data_level ? 8'd1 : 8'hFF)
                                   : main_pos_reg;
    assign sub_base      = main_go ? '0 : sub_pos_reg;
    assign sub_pos_next  = sub_go ? sub_base + (sub_data_level ? 8'd1 : 8'hFF) : sub_base;

    assign talk_down    = !talk_button_level;
    assign confirm_down = !confirm_switch_level;

    assign talk_guard_ok    = !talk_valid_reg
                              || ((now_ms - talk_rel_reg) >= {16'd0, guard_reg});
    assign confirm_guard_ok = (now_ms - confirm_rel_reg) >= {16'd0, guard_reg};

    assign talk_press    = !warm && talk_down && !talk_held_reg && talk_guard_ok;
    assign talk_rel      = !warm && !talk_down && talk_held_reg;
    assign confirm_press = !warm && confirm_down && !confirm_held_reg && confirm_guard_ok;
    assign confirm_rel   = !warm && !confirm_down && confirm_held_reg;

    always_comb begin
        rec_data.ev_mask               = '0;
        rec_data.ev_mask[EV_MAIN]      = main_go;
        rec_data.ev_mask[EV_SUB]       = sub_go;
        rec_data.ev_mask[EV_TALK]      = talk_press || talk_rel;
        rec_data.ev_mask[EV_CONFIRM]   = confirm_press;
        rec_data.talk_release          = talk_rel;
        rec_data.main_pos              = main_pos_next;
        rec_data.sub_pos               = sub_pos_next;
        rec_data.now_ms                = now_ms;
    end

    assign rec_push = tick_accept && (main_go || sub_go || talk_press || talk_rel
                                      || confirm_press);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_deb_reg <= 16'd50;
            rate_lim_reg <= 16'd100;
            guard_reg    <= 16'd100;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_STEP_DEBOUNCE: step_deb_reg <= cfg_wdata;
                CFG_ROTATE_LIMIT:  rate_lim_reg <= cfg_wdata;
                CFG_RELEASE_GUARD: guard_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_prev_reg    <= 1'b1;
            sub_prev_reg     <= 1'b1;
            main_step_reg    <= '0;
            sub_step_reg     <= '0;
            main_evt_reg     <= '0;
            sub_evt_reg      <= '0;
            main_pos_reg     <= '0;
            sub_pos_reg      <= '0;
            talk_held_reg    <= 1'b0;
            talk_valid_reg   <= 1'b0;
            talk_rel_reg     <= '0;
            confirm_held_reg <= 1'b0;
            confirm_rel_reg  <= '0;
            tick_reg         <= '0;
        end else if (tick_accept) begin
            tick_reg      <= tick_next;
            main_prev_reg <= main_clock_level;
            sub_prev_reg  <= sub_clock_level;
            if (main_edge) begin
                main_step_reg <= now_ms;
            end
            if (sub_edge) begin
                sub_step_reg <= now_ms;
            end
            if (warm) begin
                talk_held_reg    <= 1'b0;
                talk_valid_reg   <= 1'b0;
                confirm_held_reg <= confirm_down;
            end else begin
                main_pos_reg <= main_pos_next;
                sub_pos_reg  <= sub_pos_next;
                if (main_go) begin
                    main_evt_reg <= now_ms;
                end
                if (sub_go) begin
                    sub_evt_reg <= now_ms;
                end
                if (talk_press) begin
                    talk_held_reg <= 1'b1;
                end else if (talk_rel) begin
                    talk_held_reg  <= 1'b0;
                    talk_rel_reg   <= now_ms;
                    talk_valid_reg <= 1'b1;
                end
                if (confirm_press) begin
                    confirm_held_reg <= 1'b1;
                end else if (confirm_rel) begin
                    confirm_held_reg <= 1'b0;
                    confirm_rel_reg  <= now_ms;
                end
            end
        end
    end

endmodule

// ----- hw/rtl/demeg_queue.sv -----
`timescale 1ns / 1ps
// Small FIFO of tick records between the front and back ends.
// Uses demeg_pkg for the record type.
module demeg_queue #(
    parameter int DEPTH = 4
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  demeg_pkg::tick_rec_t push_data,
    input  logic                 pop,
    output demeg_pkg::tick_rec_t head,
    output logic                 empty,
    output logic                 full
);
    import demeg_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    tick_rec_t        mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == CNT_W'(DEPTH));
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ----- hw/rtl/demeg_back.sv -----
`timescale 1ns / 1ps
// Back end: walks the head tick record's events one per cycle into the output
// register when free. Uses demeg_pkg for the record type and event codes.
module demeg_back (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  demeg_pkg::tick_rec_t            head,
    input  logic                            q_empty,
    output logic                            q_pop,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [demeg_pkg::M_DATA_W-1:0]  m_tdata,
    output logic                            m_tlast,
    output logic [demeg_pkg::KIND_W-1:0]    m_tuser
);
    import demeg_pkg::*;

    logic [NUM_EV-1:0]   done_reg, done_next;
    logic                valid_reg, valid_next;
    logic [M_DATA_W-1:0] data_reg, data_next;
    logic                last_reg, last_next;
    logic [KIND_W-1:0]   kind_reg, kind_next;

    logic [NUM_EV-1:0] pending, sel;
    logic              load_ok, emit, is_last;
    logic [KIND_W-1:0] kind;
    logic [POS_W-1:0]  sub_field;

    assign pending = head.ev_mask & ~done_reg;
    assign sel     = pending & (~pending + 1'b1);   // lowest pending event
    assign is_last = ((pending & ~sel) == '0);
    assign load_ok = !valid_reg || m_tready;
    assign emit    = load_ok && !q_empty;
    assign q_pop   = emit && is_last;

    always_comb begin
        kind      = KIND_CONFIRM;
        sub_field = head.sub_pos;
        if (sel[EV_MAIN]) begin
            kind      = KIND_MAIN_ROTATE;
            sub_field = '0;
        end else if (sel[EV_SUB]) begin
            kind = KIND_SUB_ROTATE;
        end else if (sel[EV_TALK]) begin
            kind = head.talk_release ? KIND_TALK_RELEASE : KIND_TALK_PRESS;
        end
    end

    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        last_next  = last_reg;
        kind_next  = kind_reg;
        done_next  = done_reg;
        if (emit) begin
            valid_next = 1'b1;
            data_next  = {head.now_ms, sub_field, head.main_pos};
            last_next  = is_last;
            kind_next  = kind;
            done_next  = is_last ? '0 : (done_reg | sel);
        end else if (load_ok) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            done_reg  <= '0;
        end else begin
            valid_reg <= valid_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        last_reg <= last_next;
        kind_reg <= kind_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;
    assign m_tuser  = kind_reg;

endmodule

// ----- hw/rtl/dual_encoder_menu_event_generator_top.sv -----
`timescale 1ns / 1ps
// Top level of the dual encoder menu event generator.
// Depends on demeg_pkg, demeg_front, demeg_queue and demeg_back.

// Each input word is one polling tick: a millisecond time stamp, the clock and
// data levels of a main and a sub rotary encoder, and two active-low buttons.
// The front end takes one tick per clock cycle while the record queue has room,
// updates the encoder positions, debounce stamps and button states at once, and
// stores a record for any tick that produces events. The back end emits those
// events one per cycle while the receiver takes them, in the order main rotate,
// sub rotate, talk press or release, confirm, with tlast on the final event of
// the tick. A tick is one input word and gives as many event words as it has
// events (zero to four); the output register holds a waiting event while the
// front end keeps accepting ticks, and the input stalls only when the queue of
// QUEUE_DEPTH records is full. The first WARMUP_TICKS - 1 ticks after reset only
// sample the pins and produce nothing. Configuration writes take effect on the
// next clock edge and are meant to be made while the block is idle.
module dual_encoder_menu_event_generator_top #(
    parameter int WARMUP_TICKS = 10,
    parameter int QUEUE_DEPTH  = 4
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Configuration: index 0 step debounce, 1 rotate rate limit, 2 release guard.
    input  logic                             cfg_wr_en,
    input  logic [demeg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [demeg_pkg::CFG_W-1:0]      cfg_wdata,
    // Tick input stream.
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // From bit 0: now_ms[31:0], main_clock_level[32], main_data_level[33],
    // sub_clock_level[34], sub_data_level[35], talk_button_level[36],
    // confirm_switch_level[37], zero padding[39:38].
    input  logic [demeg_pkg::S_DATA_W-1:0]   s_tdata,
    // Event output stream; tlast is last_of_tick.
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // From bit 0: main_position[7:0], sub_position[15:8], event_time_ms[47:16].
    output logic [demeg_pkg::M_DATA_W-1:0]   m_tdata,
    output logic                             m_tlast,
    // event_kind[2:0].
    output logic [demeg_pkg::KIND_W-1:0]     m_tuser
);
    import demeg_pkg::*;

    logic      q_full, q_empty, q_pop, rec_push, tick_accept;
    tick_rec_t rec_data, head;

    // Backpressure comes from the queue alone, so the input never waits on the
    // output handshake directly.
    assign s_tready    = !q_full;
    assign tick_accept = s_tvalid && s_tready;

    demeg_front #(
        .WARMUP_TICKS(WARMUP_TICKS)
    ) u_front (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_wr_en           (cfg_wr_en),
        .cfg_index           (cfg_index),
        .cfg_wdata           (cfg_wdata),
        .tick_accept         (tick_accept),
        .now_ms              (s_tdata[31:0]),
        .main_clock_level    (s_tdata[32]),
        .main_data_level     (s_tdata[33]),
        .sub_clock_level     (s_tdata[34]),
        .sub_data_level      (s_tdata[35]),
        .talk_button_level   (s_tdata[36]),
        .confirm_switch_level(s_tdata[37]),
        .rec_push            (rec_push),
        .rec_data            (rec_data)
    );

    demeg_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (rec_push),
        .push_data(rec_data),
        .pop      (q_pop),
        .head     (head),
        .empty    (q_empty),
        .full     (q_full)
    );

    demeg_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .head    (head),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast),
        .m_tuser (m_tuser)
    );

endmodule

// ----- sim/dual_encoder_menu_event_generator_top_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the dual encoder menu event generator top level.
// Depends on demeg_pkg and dual_encoder_menu_event_generator_top; tick words go in,
// event words are checked in order against an in-bench event predictor.
module dual_encoder_menu_event_generator_top_test;
    import demeg_pkg::*;

    // The block's warm-up length; the predictor uses the same value.
    localparam int WARMUP_TICKS = 10;
    // The register port can address index 3, which the block must ignore.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_INDEX = 2'd3;
    // A directed row whose outcome is left to the predictor.
    localparam int PREDICTED = -1;
    localparam int NUM_PHASES = 6;
    localparam int TICKS_PER_PHASE = 46;
    // Extra cycles allowed after the last event before a register write or the end.
    // A tick that gives no event still updates the front end at the edge that
    // takes it.
    localparam int SETTLE_CYCLES = 8;
    localparam int REPORT_LIMIT = 10;

    // One polling tick, laid out so that {2'b00, tick} is the input word.
    typedef struct packed {
        logic        confirm;
        logic        talk;
        logic        sub_data;
        logic        sub_clk;
        logic        main_data;
        logic        main_clk;
        logic [31:0] now_ms;
    } tick_t;

    // One event word as it leaves the block.
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [POS_W-1:0]  main_pos;
        logic [POS_W-1:0]  sub_pos;
        logic [TIME_W-1:0] stamp;
        logic              last;
    } evt_t;

    // A row of the directed table: the tick, and either a typed-in outcome
    // (zero or one event) or PREDICTED.
    typedef struct {
        tick_t tick;
        int    typed_n;
        evt_t  typed_ev;
    } directed_row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wdata;
    logic                 s_tvalid;
    logic                 s_tready;
    // From bit 0: now_ms[31:0], main_clock_level, main_data_level, sub_clock_level,
    // sub_data_level, talk_button_level, confirm_switch_level, two zero bits.
    logic [S_DATA_W-1:0]  s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    // From bit 0: main_position[7:0], sub_position[15:8], event_time_ms[47:16].
    logic [M_DATA_W-1:0]  m_tdata;
    logic                 m_tlast;
    // event_kind[2:0].
    logic [KIND_W-1:0]    m_tuser;

    dual_encoder_menu_event_generator_top #(
        .WARMUP_TICKS(WARMUP_TICKS)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Predictor copy of the registers.
    logic [CFG_W-1:0] step_debounce;
    logic [CFG_W-1:0] rotate_limit;
    logic [CFG_W-1:0] release_guard;

    // Predictor copy of the block state.
    logic             main_clk_prev;
    logic             sub_clk_prev;
    logic [31:0]      main_step_stamp;
    logic [31:0]      sub_step_stamp;
    logic [POS_W-1:0] main_pos;
    logic [POS_W-1:0] sub_pos;
    logic [31:0]      main_rotate_stamp;
    logic [31:0]      sub_rotate_stamp;
    logic             talk_down_held;
    logic             talk_released;
    logic [31:0]      talk_release_stamp;
    logic             confirm_down_held;
    logic [31:0]      confirm_release_stamp;
    int               ticks_seen;

    // Events of the tick being predicted, and the events still owed by the block.
    evt_t tick_events[$];
    evt_t pending_events[$];
    directed_row_t directed_rows[$];

    tick_t prev_tick;
    int    sender_idle_pct;
    int    receiver_stall_pct;
    int    mismatch_count;
    int    ticks_sent;
    int    events_checked;
    int    settings_used;
    evt_t  seen_event;
    evt_t  want_event;

    // ------------------------------------------------------------------
    // Event predictor
    // ------------------------------------------------------------------

    // One encoder sample: a falling clock edge outside the debounce window is a
    // step, +1 with data high and -1 with data low. The clock is always recorded.
    task automatic sample_encoder(input logic [31:0] now, input logic clk,
                                  input logic dat, inout logic prev,
                                  inout logic [31:0] stamp, output int dir);
        logic [31:0] elapsed;
        elapsed = now - stamp;
        dir = 0;
        if (elapsed >= {16'h0000, step_debounce} && prev && !clk) begin
            dir = dat ? 1 : -1;
            stamp = now;
        end
        prev = clk;
    endtask

    task automatic add_event(input logic [KIND_W-1:0] kind, input logic [POS_W-1:0] sub,
                             input logic [31:0] now);
        tick_events.push_back('{kind: kind, main_pos: main_pos, sub_pos: sub,
                                stamp: now, last: 1'b0});
    endtask

    // Works out the events of one tick into tick_events and advances the state.
    task automatic predict_events(input tick_t t);
        int          main_dir;
        int          sub_dir;
        logic        talk_down;
        logic        confirm_down;
        logic [31:0] now;
        evt_t        tail;
        now = t.now_ms;
        talk_down = !t.talk;
        confirm_down = !t.confirm;
        tick_events.delete();
        if (ticks_seen < WARMUP_TICKS)
            ticks_seen++;
        // Both encoders track their pins even during warm-up.
        sample_encoder(now, t.main_clk, t.main_data, main_clk_prev, main_step_stamp,
                       main_dir);
        sample_encoder(now, t.sub_clk, t.sub_data, sub_clk_prev, sub_step_stamp, sub_dir);
        if (ticks_seen < WARMUP_TICKS) begin
            // Warm-up: steps are thrown away and the buttons are only sampled.
            talk_down_held = 1'b0;
            talk_released = 1'b0;
            confirm_down_held = confirm_down;
        end else begin
            if (main_dir != 0 && now - main_rotate_stamp >= {16'h0000, rotate_limit}) begin
                main_pos = main_pos + ((main_dir > 0) ? 8'd1 : 8'hFF);
                sub_pos = '0;
                add_event(KIND_MAIN_ROTATE, '0, now);
                main_rotate_stamp = now;
            end
            if (sub_dir != 0 && now - sub_rotate_stamp >= {16'h0000, rotate_limit}) begin
                sub_pos = sub_pos + ((sub_dir > 0) ? 8'd1 : 8'hFF);
                add_event(KIND_SUB_ROTATE, sub_pos, now);
                sub_rotate_stamp = now;
            end
            if (talk_down && !talk_down_held) begin
                // The guard only applies once a real release has been seen.
                if (!talk_released ||
                    now - talk_release_stamp >= {16'h0000, release_guard}) begin
                    talk_down_held = 1'b1;
                    add_event(KIND_TALK_PRESS, sub_pos, now);
                end
            end else if (!talk_down && talk_down_held) begin
                talk_down_held = 1'b0;
                talk_release_stamp = now;
                talk_released = 1'b1;
                add_event(KIND_TALK_RELEASE, sub_pos, now);
            end
            if (confirm_down && !confirm_down_held) begin
                if (now - confirm_release_stamp >= {16'h0000, release_guard}) begin
                    confirm_down_held = 1'b1;
                    add_event(KIND_CONFIRM, sub_pos, now);
                end
            end else if (!confirm_down && confirm_down_held) begin
                // A confirm release is silent; it only starts the guard.
                confirm_down_held = 1'b0;
                confirm_release_stamp = now;
            end
        end
        if (tick_events.size() > 0) begin
            tail = tick_events.pop_back();
            tail.last = 1'b1;
            tick_events.push_back(tail);
        end
    endtask

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Writes one register and mirrors it into the predictor; index 3 is ignored.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_STEP_DEBOUNCE: step_debounce = val;
            CFG_ROTATE_LIMIT:  rotate_limit = val;
            CFG_RELEASE_GUARD: release_guard = val;
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic apply_settings(input logic [CFG_W-1:0] debounce,
                                  input logic [CFG_W-1:0] limit,
                                  input logic [CFG_W-1:0] guard);
        write_reg(CFG_STEP_DEBOUNCE, debounce);
        write_reg(CFG_ROTATE_LIMIT, limit);
        write_reg(CFG_RELEASE_GUARD, guard);
        settings_used++;
    endtask

    // Offers one tick, with random idle cycles in front, and books its events
    // once the block has taken it.
    task automatic send_tick(input tick_t t, input int typed_n, input evt_t typed_ev);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {2'b00, t};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        predict_events(t);
        if (typed_n == PREDICTED) begin
            foreach (tick_events[k])
                pending_events.push_back(tick_events[k]);
        end else if (typed_n == 1) begin
            pending_events.push_back(typed_ev);
        end
        prev_tick = t;
        ticks_sent++;
    endtask

    // Waits until every booked event has come out.
    task automatic wait_events_out();
        s_tvalid <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge aclk);
    endtask

    // Same, then lets the block finish any tick that had no events.
    task automatic wait_idle();
        wait_events_out();
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic add_row(input logic [31:0] now, input logic mclk, input logic mdat,
                           input logic sclk, input logic sdat, input logic talk,
                           input logic confirm, input int typed_n,
                           input logic [KIND_W-1:0] kind, input logic [POS_W-1:0] mpos,
                           input logic [POS_W-1:0] spos);
        directed_row_t row;
        row.tick = '{confirm: confirm, talk: talk, sub_data: sdat, sub_clk: sclk,
                     main_data: mdat, main_clk: mclk, now_ms: now};
        row.typed_n = typed_n;
        row.typed_ev = '{kind: kind, main_pos: mpos, sub_pos: spos, stamp: now, last: 1'b1};
        directed_rows.push_back(row);
    endtask

    // Random ticks are mostly plausible pin activity: clocks that toggle, buttons
    // that are held for a while, time moving forward in small steps. Now and then
    // a big jump in time, a wrap of the time stamp, or a tick of pure noise.
    task automatic next_random_tick(output tick_t t);
        int          pick;
        logic [31:0] dt;
        logic [31:0] noise;
        pick = $urandom_range(99);
        if (pick < 70)
            dt = $urandom_range(200);
        else if (pick < 90)
            dt = $urandom_range(70000);
        else
            dt = $urandom;
        t = prev_tick;
        t.now_ms = prev_tick.now_ms + dt;
        if ($urandom_range(9) == 0) begin
            noise = $urandom;
            {t.confirm, t.talk, t.sub_data, t.sub_clk, t.main_data, t.main_clk} = noise[5:0];
        end else begin
            if ($urandom_range(99) < 60)
                t.main_clk = !prev_tick.main_clk;
            if ($urandom_range(99) < 60)
                t.sub_clk = !prev_tick.sub_clk;
            t.main_data = 1'($urandom_range(1));
            t.sub_data = 1'($urandom_range(1));
            if ($urandom_range(99) < 25)
                t.talk = !prev_tick.talk;
            if ($urandom_range(99) < 25)
                t.confirm = !prev_tick.confirm;
        end
    endtask

    // ------------------------------------------------------------------
    // Event checker and receiver
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string why, input evt_t want, input evt_t seen);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
            $display("%0t %s: expected kind %0d main %0d sub %0d at %0d last %0d,",
                     $realtime, why, want.kind, want.main_pos, want.sub_pos, want.stamp,
                     want.last);
            $display("    got kind %0d main %0d sub %0d at %0d last %0d",
                     seen.kind, seen.main_pos, seen.sub_pos, seen.stamp, seen.last);
        end
    endtask

    // Every event word taken off the output is compared with the oldest booked event.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            seen_event = '{kind: m_tuser, main_pos: m_tdata[7:0], sub_pos: m_tdata[15:8],
                           stamp: m_tdata[47:16], last: m_tlast};
            events_checked++;
            if (pending_events.size() == 0) begin
                report_mismatch("event word with nothing pending", '0, seen_event);
            end else begin
                want_event = pending_events.pop_front();
                if (seen_event !== want_event)
                    report_mismatch("event word mismatch", want_event, seen_event);
            end
        end
    end

    // The receiver stalls at random with the current phase's percentage.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    initial begin : stimulus
        tick_t t;
        evt_t  none;
        int    p;
        int    i;
        logic  pause_midway;

        none = '0;
        aresetn <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= CFG_STEP_DEBOUNCE;
        cfg_wdata <= '0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        mismatch_count = 0;
        ticks_sent = 0;
        events_checked = 0;
        settings_used = 1;

        // Predictor starts from the reset state.
        step_debounce = 16'd50;
        rotate_limit = 16'd100;
        release_guard = 16'd100;
        main_clk_prev = 1'b1;
        sub_clk_prev = 1'b1;
        main_step_stamp = '0;
        sub_step_stamp = '0;
        main_pos = '0;
        sub_pos = '0;
        main_rotate_stamp = '0;
        sub_rotate_stamp = '0;
        talk_down_held = 1'b0;
        talk_released = 1'b0;
        talk_release_stamp = '0;
        confirm_down_held = 1'b0;
        confirm_release_stamp = '0;
        ticks_seen = 0;
        prev_tick = '0;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed table, run with the reset settings (debounce 50, rate limit
        // 100, release guard 100). Columns: time, main clk/data, sub clk/data,
        // talk, confirm, typed event count, kind, main and sub position.
        // Warm-up: edges and presses are sampled but nothing comes out.
        add_row(0,   1, 0, 1, 0, 1, 1, 0, KIND_MAIN_ROTATE, 0, 0);
        add_row(60,  0, 1, 1, 0, 1, 1, 0, KIND_MAIN_ROTATE, 0, 0);
        add_row(70,  1, 1, 1, 0, 1, 1, 0, KIND_MAIN_ROTATE, 0, 0);
        add_row(80,  1, 0, 0, 0, 1, 1, 0, KIND_MAIN_ROTATE, 0, 0);
        add_row(90,  1, 0, 1, 1, 1, 1, 0, KIND_MAIN_ROTATE, 0, 0);
        add_row(100, 1, 0, 1, 1, 0, 1, 0, KIND_MAIN_ROTATE, 0, 0);
        add_row(110, 1, 0, 1, 1, 0, 0, 0, KIND_MAIN_ROTATE, 0, 0);
        add_row(120, 1, 0, 1, 1, 1, 0, 0, KIND_MAIN_ROTATE, 0, 0);
        add_row(130, 1, 1, 1, 1, 0, 0, 0, KIND_MAIN_ROTATE, 0, 0);
        // First live tick: talk press with no release yet skips the guard, while
        // confirm was already down during warm-up and stays silent.
        add_row(200, 1, 1, 1, 1, 0, 0, 1, KIND_TALK_PRESS, 0, 0);
        add_row(300, 1, 1, 1, 1, 1, 1, 1, KIND_TALK_RELEASE, 0, 0);
        // Both presses fall inside the release guard.
        add_row(350, 1, 1, 1, 1, 0, 0, 0, KIND_MAIN_ROTATE, 0, 0);
        add_row(450, 1, 1, 1, 1, 0, 0, PREDICTED, KIND_MAIN_ROTATE, 0, 0);
        add_row(500, 1, 1, 1, 1, 1, 1, PREDICTED, KIND_MAIN_ROTATE, 0, 0);
        // First main step, then one inside the step debounce window.
        add_row(600, 0, 1, 1, 1, 1, 1, 1, KIND_MAIN_ROTATE, 1, 0);
        add_row(610, 1, 1, 1, 1, 1, 1, PREDICTED, KIND_MAIN_ROTATE, 0, 0);
        add_row(620, 0, 0, 1, 1, 1, 1, PREDICTED, KIND_MAIN_ROTATE, 0, 0);
        add_row(700, 1, 0, 1, 1, 1, 1, PREDICTED, KIND_MAIN_ROTATE, 0, 0);
        // Main steps down, sub steps down through zero, then a rate-limited step.
        add_row(710, 0, 0, 1, 1, 1, 1, PREDICTED, KIND_MAIN_ROTATE, 0, 0);
        add_row(720, 1, 0, 0, 0, 1, 1, PREDICTED, KIND_MAIN_ROTATE, 0, 0);
        add_row(780, 0, 1, 1, 0, 1, 1, PREDICTED, KIND_MAIN_ROTATE, 0, 0);
        // Buttons, then both encoders with a main wrap below zero.
        add_row(900, 1, 1, 1, 1, 0, 0, PREDICTED, KIND_MAIN_ROTATE, 0, 0);
        add_row(1000, 0, 0, 0, 1, 1, 1, PREDICTED, KIND_MAIN_ROTATE, 0, 0);
        add_row(1300, 1, 1, 1, 1, 1, 1, PREDICTED, KIND_MAIN_ROTATE, 0, 0);
        // All four events in one tick.
        add_row(1500, 0, 1, 0, 1, 0, 0, PREDICTED, KIND_MAIN_ROTATE, 0, 0);
        // Time stamp at the top of its range, then wrapped past zero.
        add_row(32'hFFFF_FFF0, 1, 1, 1, 1, 1, 1, PREDICTED, KIND_MAIN_ROTATE, 0, 0);
        add_row(32'h0000_0020, 0, 0, 0, 0, 1, 1, PREDICTED, KIND_MAIN_ROTATE, 0, 0);

        foreach (directed_rows[k])
            send_tick(directed_rows[k].tick, directed_rows[k].typed_n,
                      directed_rows[k].typed_ev);
        wait_idle();

        // A write to the unused index must not disturb anything.
        write_reg(CFG_SPARE_INDEX, CFG_W'($urandom));

        // Random phases, each with its own settings and idle pattern.
        for (p = 0; p < NUM_PHASES; p++) begin
            pause_midway = 1'b0;
            case (p)
                0: begin
                    apply_settings(16'd0, 16'd0, 16'd0);
                    sender_idle_pct = 0;
                    receiver_stall_pct = 0;
                end
                1: begin
                    apply_settings(16'd50, 16'd100, 16'd100);
                    sender_idle_pct = 56;
                    receiver_stall_pct = 0;
                end
                2: begin
                    apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF);
                    sender_idle_pct = 0;
                    receiver_stall_pct = 56;
                end
                3: begin
                    apply_settings(CFG_W'($urandom_range(300)), CFG_W'($urandom_range(300)),
                                   CFG_W'($urandom_range(300)));
                    sender_idle_pct = 11;
                    receiver_stall_pct = 11;
                end
                4: begin
                    apply_settings(CFG_W'($urandom_range(300)), CFG_W'($urandom_range(300)),
                                   CFG_W'($urandom_range(300)));
                    sender_idle_pct = 0;
                    receiver_stall_pct = 0;
                    pause_midway = 1'b1;
                end
                default: begin
                    apply_settings(CFG_W'($urandom_range(300)),
                                   CFG_W'($urandom_range(65535)),
                                   CFG_W'($urandom_range(300)));
                    sender_idle_pct = 56;
                    receiver_stall_pct = 56;
                end
            endcase
            for (i = 0; i < TICKS_PER_PHASE; i++) begin
                // Stop feeding until the block has emptied out, then carry on.
                if (pause_midway && i == TICKS_PER_PHASE / 2)
                    wait_events_out();
                next_random_tick(t);
                send_tick(t, PREDICTED, none);
            end
            wait_idle();
        end

        $display("Covered %0d ticks (%0d directed) and %0d event words",
                 ticks_sent, directed_rows.size(), events_checked);
        $display("under %0d register settings, with sender gaps and receiver stalls.",
                 settings_used);
        if (mismatch_count == 0 && pending_events.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d mismatches, %0d events never seen", mismatch_count,
                     pending_events.size());
            $display("status: fail");
        end
        $finish;
    end

    // Watchdog: the slowest correct run needs well under a tenth of this.
    initial begin
        #2_000_000;
        $display("Timeout with %0d events still pending", pending_events.size());
        $display("status: fail");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/demeg_pkg.sv
hw/rtl/demeg_front.sv
hw/rtl/demeg_queue.sv
hw/rtl/demeg_back.sv
hw/rtl/dual_encoder_menu_event_generator_top.sv
sim/dual_encoder_menu_event_generator_top_test.sv
